// File: rtl/kef_pkg.sv
// ----------------------------------------------------------------------------
// kef_pkg
// Shared types, command codes and the default key bindings of the keyboard
// event unit.
// ----------------------------------------------------------------------------
package kef_pkg;

  // Command codes
  localparam logic [2:0] CMD_KEY_DOWN = 3'd0;
  localparam logic [2:0] CMD_PUSH     = 3'd1;
  localparam logic [2:0] CMD_BIND     = 3'd2;
  localparam logic [2:0] CMD_POP      = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;
  localparam logic [2:0] CMD_RESTORE  = 3'd5;

  // Highest valid game event
  localparam logic [3:0] LAST_EVENT = 4'd9;

  // Number of bindings loaded at reset and on restore
  localparam int DEFAULT_BINDINGS = 9;

  // Request item
  typedef struct packed {
    logic [2:0] cmd;
    logic [8:0] scancode;
    logic       is_repeat;
    logic [3:0] event_code;
  } kef_in_t;

  // Result item
  typedef struct packed {
    logic       ok;
    logic [3:0] event_out;
    logic       dropped_oldest;
    logic [4:0] queue_count;
  } kef_out_t;

  // One key map binding
  typedef struct packed {
    logic [8:0] key;
    logic [3:0] evt;
  } kef_entry_t;

  // Read result of the key map
  typedef struct packed {
    logic       valid;
    kef_entry_t entry;
  } kef_map_rd_t;

  // Default scancode of binding i (i below DEFAULT_BINDINGS)
  function automatic logic [8:0] dflt_key(input logic [3:0] i);
    logic [8:0] k;
    case (i)
      4'd0:    k = 9'd26;
      4'd1:    k = 9'd22;
      4'd2:    k = 9'd4;
      4'd3:    k = 9'd7;
      4'd4:    k = 9'd41;
      4'd5:    k = 9'd19;
      4'd6:    k = 9'd62;
      4'd7:    k = 9'd66;
      4'd8:    k = 9'd60;
      default: k = 9'd0;
    endcase
    return k;
  endfunction

  // True for a game event that may enter the queue
  function automatic logic evt_ok(input logic [3:0] e);
    return (e != 4'd0) && (e <= LAST_EVENT);
  endfunction

endpackage

// File: rtl/kef_map.sv
// ----------------------------------------------------------------------------
// kef_map
// Key map storage: one synchronous memory of bindings with a registered read,
// plus per-entry valid and written flags. An entry never written since reset
// or restore reads back its default binding.
// ----------------------------------------------------------------------------
module kef_map import kef_pkg::*; #(
  parameter int MAP_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             restore,
  input  logic [$clog2(MAP_ENTRIES)-1:0]   rd_addr,
  output kef_map_rd_t                      rd,
  input  logic                             wr_en,
  input  logic [$clog2(MAP_ENTRIES)-1:0]   wr_addr,
  input  kef_entry_t                       wr_entry
);

  localparam int IDX_W = $clog2(MAP_ENTRIES);

  kef_entry_t             mem [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] valid;
  logic [MAP_ENTRIES-1:0] written;

  kef_entry_t             rd_q;
  logic                   valid_q;
  logic                   written_q;
  logic [IDX_W-1:0]       addr_q;
  kef_entry_t             dflt;

  // Binding memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_q      <= mem[rd_addr];
    valid_q   <= valid[rd_addr];
    written_q <= written[rd_addr];
    addr_q    <= rd_addr;
  end

  // Valid and written flags; reset and restore bring back the defaults
  always_ff @(posedge clk) begin
    if (rst || restore) begin
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        valid[i]   <= (i < DEFAULT_BINDINGS);
        written[i] <= 1'b0;
      end
    end else if (wr_en) begin
      valid[wr_addr]   <= 1'b1;
      written[wr_addr] <= 1'b1;
    end
  end

  // Default binding of the entry just read
  always_comb begin
    dflt = '0;
    if (addr_q < IDX_W'(DEFAULT_BINDINGS)) begin
      dflt.key = dflt_key(addr_q[3:0]);
      dflt.evt = addr_q[3:0] + 4'd1;
    end
  end

  assign rd.valid = valid_q;
  assign rd.entry = written_q ? rd_q : dflt;

endmodule

// File: rtl/keymap_event_fifo.sv
// ----------------------------------------------------------------------------
// keymap_event_fifo
// Keyboard event unit: scancode-to-event key map and a drop-oldest event queue.
// ----------------------------------------------------------------------------
// Usage:
//   req / req_valid / req_ready carries command items (key down, push, bind,
//   pop, clear queue, restore default map). rsp / rsp_valid / rsp_ready returns
//   exactly one result item per command item, in order.
//   One item is worked on at a time; req_ready is high while the unit is idle,
//   also while the previous result still waits in the output register.
//   Key down (not autorepeat) and a bind of an in-range event first scan the
//   map and then finish; a key down that maps to a valid event then passes
//   the push state, as does a push of a valid event, and a pop of a non-empty
//   queue passes the pop state. Every item ends in the result state, which
//   loads the output register. The map scan reads one map memory entry per
//   cycle over all MAP_ENTRIES entries. The unit is ready again as soon as a
//   result is loaded into the output register.
//   Reset empties the queue and loads the nine default bindings at once.
//   A stalled receiver holds the result in the output register; the unit then
//   takes one more item and waits with its result until the register frees.
// ----------------------------------------------------------------------------
module keymap_event_fifo import kef_pkg::*; #(
  parameter int MAP_ENTRIES = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  kef_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output kef_out_t rsp
);

  localparam int IDX_W  = $clog2(MAP_ENTRIES);
  localparam int SCAN_W = $clog2(MAP_ENTRIES + 1);
  localparam int QP_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_PUSH,
    S_POP,
    S_RESULT
  } state_t;

  state_t            state;
  kef_in_t           item;

  // Scan bookkeeping
  logic [SCAN_W-1:0] scan_idx;
  logic              scan_live;
  logic              scan_done;
  logic [IDX_W-1:0]  cmp_idx;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [3:0]        found_evt;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;

  // Queue
  logic [3:0]        qmem [QUEUE_DEPTH];
  logic [3:0]        q_rd;
  logic [QP_W-1:0]   head;
  logic [QP_W-1:0]   tail;
  logic [CNT_W-1:0]  count;
  logic              full;
  logic [3:0]        push_evt;
  logic              push_we;

  // Result under construction
  logic              res_ok;
  logic [3:0]        res_evt;
  logic              res_drop;

  // Map port
  kef_map_rd_t       map_rd;
  logic              map_restore;
  logic              map_we;
  logic [IDX_W-1:0]  map_waddr;
  kef_entry_t        map_wentry;

  function automatic logic [QP_W-1:0] next_slot(input logic [QP_W-1:0] p);
    return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign req_ready   = (state == S_IDLE);
  assign scan_done   = (scan_idx == SCAN_W'(MAP_ENTRIES));
  assign full        = (count == CNT_W'(QUEUE_DEPTH));
  assign push_we     = (state == S_PUSH);
  assign map_restore = (state == S_IDLE) && req_valid && (req.cmd == CMD_RESTORE);

  // Bind writes the matching entry, else the first empty one
  assign map_we         = (state == S_FINISH) && (item.cmd == CMD_BIND)
                          && (found || empty_found);
  assign map_waddr      = found ? found_idx : empty_idx;
  assign map_wentry.key = item.scancode;
  assign map_wentry.evt = item.event_code;

  kef_map #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .restore  (map_restore),
    .rd_addr  (scan_idx[IDX_W-1:0]),
    .rd       (map_rd),
    .wr_en    (map_we),
    .wr_addr  (map_waddr),
    .wr_entry (map_wentry)
  );

  // Event queue memory, read continuously at the head
  always_ff @(posedge clk) begin
    if (push_we) begin
      qmem[tail] <= push_evt;
    end
    q_rd <= qmem[head];
  end

  // Sequencer, queue pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      scan_live <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // The result state reloads the register itself
      if (rsp_valid && rsp_ready && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item        <= req;
            res_evt     <= 4'd0;
            res_drop    <= 1'b0;
            scan_idx    <= '0;
            scan_live   <= 1'b0;
            found       <= 1'b0;
            empty_found <= 1'b0;
            case (req.cmd)
              CMD_KEY_DOWN: begin
                res_ok <= 1'b0;
                state  <= req.is_repeat ? S_RESULT : S_SCAN;
              end
              CMD_PUSH: begin
                res_ok <= 1'b0;
                if (evt_ok(req.event_code)) begin
                  push_evt <= req.event_code;
                  state    <= S_PUSH;
                end else begin
                  state <= S_RESULT;
                end
              end
              CMD_BIND: begin
                res_ok <= 1'b0;
                state  <= (req.event_code <= LAST_EVENT) ? S_SCAN : S_RESULT;
              end
              CMD_POP: begin
                res_ok <= 1'b0;
                state  <= (count != '0) ? S_POP : S_RESULT;
              end
              CMD_CLEAR: begin
                head   <= '0;
                tail   <= '0;
                count  <= '0;
                res_ok <= 1'b1;
                state  <= S_RESULT;
              end
              CMD_RESTORE: begin
                res_ok <= 1'b1;
                state  <= S_RESULT;
              end
              default: begin
                res_ok <= 1'b0;
                state  <= S_RESULT;
              end
            endcase
          end
        end

        // One map read issued per cycle, compared in the next cycle
        S_SCAN: begin
          scan_live <= !scan_done;
          cmp_idx   <= scan_idx[IDX_W-1:0];
          if (!scan_done) begin
            scan_idx <= scan_idx + 1'b1;
          end else begin
            state <= S_FINISH;
          end
          if (scan_live) begin
            if (map_rd.valid && (map_rd.entry.key == item.scancode) && !found) begin
              found     <= 1'b1;
              found_idx <= cmp_idx;
              found_evt <= map_rd.entry.evt;
            end
            if (!map_rd.valid && !empty_found) begin
              empty_found <= 1'b1;
              empty_idx   <= cmp_idx;
            end
          end
        end

        S_FINISH: begin
          if (item.cmd == CMD_KEY_DOWN) begin
            res_evt  <= found ? found_evt : 4'd0;
            push_evt <= found_evt;
            state    <= (found && evt_ok(found_evt)) ? S_PUSH : S_RESULT;
          end else begin
            res_ok <= found || empty_found;
            state  <= S_RESULT;
          end
        end

        // Push at the tail; on a full queue discard the oldest, count stays
        S_PUSH: begin
          tail   <= next_slot(tail);
          res_ok <= 1'b1;
          if (full) begin
            head     <= next_slot(head);
            res_drop <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
          state <= S_RESULT;
        end

        S_POP: begin
          res_evt <= q_rd;
          res_ok  <= 1'b1;
          head    <= next_slot(head);
          count   <= count - 1'b1;
          state   <= S_RESULT;
        end

        S_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid          <= 1'b1;
            rsp.ok             <= res_ok;
            rsp.event_out      <= res_evt;
            rsp.dropped_oldest <= res_drop;
            rsp.queue_count    <= 5'(count);
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Queue fill never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // A push into a full queue keeps the count
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    push_we && full |=> count == $past(count))
    else $error("count changed on drop-oldest push");

  // A new result is only loaded from the result state
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESULT))
    else $error("result raised outside result state");

  // Only one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while busy");

endmodule

// File: dv/keymap_event_fifo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keymap_event_fifo_tb
// Drives command items into the keyboard event unit and checks every result
// item against a cycle-free model of the key map and the drop-oldest queue.
// Directed items cover the corner cases; weighted random phases then fill
// the queue, fill the map and drain the queue, with random gaps on both channels.
// ----------------------------------------------------------------------------
module keymap_event_fifo_tb;
  import kef_pkg::*;

  localparam int MAP_N          = 16;
  localparam int QUEUE_N        = 16;
  localparam int HOT_KEYS       = 17;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  // Command codes the unit treats as no-ops
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  // Scancodes of the bindings loaded at reset and on restore
  localparam logic [8:0] BOOT_KEYS [DEFAULT_BINDINGS] = '{
    9'd26, 9'd22, 9'd4, 9'd7, 9'd41, 9'd19, 9'd62, 9'd66, 9'd60
  };

  // Key map and event queue mirror, plus the results still owed by the unit
  class keymap_queue_tracker;
    logic       slot_used [MAP_N];
    logic [8:0] slot_key  [MAP_N];
    logic [3:0] slot_evt  [MAP_N];
    logic [3:0] ring      [QUEUE_N];
    int         head;
    int         tail;
    int         fill;
    int         errors;
    kef_out_t   pending_results [$];

    function new();
      restore_map();
      head   = 0;
      tail   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function void restore_map();
      for (int i = 0; i < MAP_N; i++) begin
        if (i < DEFAULT_BINDINGS) begin
          slot_used[i] = 1'b1;
          slot_key[i]  = BOOT_KEYS[i];
          slot_evt[i]  = 4'(i + 1);
        end else begin
          slot_used[i] = 1'b0;
          slot_key[i]  = '0;
          slot_evt[i]  = '0;
        end
      end
    endfunction

    // Returns 1 when the oldest queued event had to go
    function bit enqueue(logic [3:0] e);
      bit lost;
      lost = 1'b0;
      if (fill >= QUEUE_N) begin
        head = (head + 1) % QUEUE_N;
        fill--;
        lost = 1'b1;
      end
      ring[tail] = e;
      tail = (tail + 1) % QUEUE_N;
      fill++;
      return lost;
    endfunction

    function logic [3:0] lookup(logic [8:0] key);
      for (int i = 0; i < MAP_N; i++)
        if (slot_used[i] && slot_key[i] == key) return slot_evt[i];
      return 4'd0;
    endfunction

    // First matching key is updated, else the first free slot is taken
    function bit rebind(logic [8:0] key, logic [3:0] e);
      int free_slot;
      free_slot = MAP_N;
      for (int i = 0; i < MAP_N; i++) begin
        if (slot_used[i] && slot_key[i] == key) begin
          slot_evt[i] = e;
          return 1'b1;
        end
        if (free_slot == MAP_N && !slot_used[i]) free_slot = i;
      end
      if (free_slot == MAP_N) return 1'b0;
      slot_used[free_slot] = 1'b1;
      slot_key[free_slot]  = key;
      slot_evt[free_slot]  = e;
      return 1'b1;
    endfunction

    function void accept_command(kef_in_t c);
      kef_out_t   r;
      logic [3:0] m;
      r = '0;
      case (c.cmd)
        CMD_KEY_DOWN: begin
          if (!c.is_repeat) begin
            m = lookup(c.scancode);
            r.event_out = m;
            if (m != 4'd0 && m <= LAST_EVENT) begin
              r.dropped_oldest = enqueue(m);
              r.ok = 1'b1;
            end
          end
        end
        CMD_PUSH: begin
          if (c.event_code != 4'd0 && c.event_code <= LAST_EVENT) begin
            r.dropped_oldest = enqueue(c.event_code);
            r.ok = 1'b1;
          end
        end
        CMD_BIND: begin
          if (c.event_code <= LAST_EVENT) r.ok = rebind(c.scancode, c.event_code);
        end
        CMD_POP: begin
          if (fill > 0) begin
            r.event_out = ring[head];
            head = (head + 1) % QUEUE_N;
            fill--;
            r.ok = 1'b1;
          end
        end
        CMD_CLEAR: begin
          head = 0;
          tail = 0;
          fill = 0;
          r.ok = 1'b1;
        end
        CMD_RESTORE: begin
          restore_map();
          r.ok = 1'b1;
        end
        default: ;
      endcase
      r.queue_count = 5'(fill);
      pending_results.push_back(r);
    endfunction

    function void match_result(kef_out_t got);
      kef_out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: ok=%0d event_out=%0d dropped_oldest=%0d queue_count=%0d",
                 $time, got.ok, got.event_out, got.dropped_oldest, got.queue_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok || got.event_out !== want.event_out ||
          got.dropped_oldest !== want.dropped_oldest ||
          got.queue_count !== want.queue_count) begin
        errors++;
        $display("%0t: mismatch: expected ok=%0d event_out=%0d dropped_oldest=%0d queue_count=%0d",
                 $time, want.ok, want.event_out, want.dropped_oldest, want.queue_count);
        $display("%0t:           actual ok=%0d event_out=%0d dropped_oldest=%0d queue_count=%0d",
                 $time, got.ok, got.event_out, got.dropped_oldest, got.queue_count);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     rsp_ready = 1'b0;
  kef_in_t  req       = '0;
  logic     req_ready;
  logic     rsp_valid;
  kef_out_t rsp;

  logic       idle_en      = 1'b1;
  int         stall_left   = 0;
  int         quiet_cycles = 0;
  logic [8:0] hot_keys [HOT_KEYS];

  keymap_queue_tracker sb = new();

  keymap_event_fifo #(
    .MAP_ENTRIES(MAP_N),
    .QUEUE_DEPTH(QUEUE_N)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stall bursts while idle_en is set
  always @(posedge clk) begin
    if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Handshake monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.accept_command(req);
      if (rsp_valid && rsp_ready) sb.match_result(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Present one item, optionally after a short gap, and hold it until taken
  task automatic send_command(input kef_in_t c);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req       <= c;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_cmd(int wk, int wp, int wb, int wo, int wc,
                                          int wr, int wx);
    int roll;
    roll = $urandom_range(0, wk + wp + wb + wo + wc + wr + wx - 1);
    if (roll < wk) return CMD_KEY_DOWN;
    roll -= wk;
    if (roll < wp) return CMD_PUSH;
    roll -= wp;
    if (roll < wb) return CMD_BIND;
    roll -= wb;
    if (roll < wo) return CMD_POP;
    roll -= wo;
    if (roll < wc) return CMD_CLEAR;
    roll -= wc;
    if (roll < wr) return CMD_RESTORE;
    return ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
  endfunction

  // Keys mostly from a small pool so presses and binds hit the map
  function automatic kef_in_t random_command(logic [2:0] cmd);
    kef_in_t c;
    c.cmd        = cmd;
    c.scancode   = ($urandom_range(0, 9) < 7) ? hot_keys[$urandom_range(0, HOT_KEYS - 1)]
                                              : 9'($urandom_range(0, 511));
    c.is_repeat  = ($urandom_range(0, 3) == 0);
    c.event_code = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 9));
    return c;
  endfunction

  task automatic run_phase(int count, int wk, int wp, int wb, int wo, int wc,
                           int wr, int wx);
    repeat (count) send_command(random_command(pick_cmd(wk, wp, wb, wo, wc, wr, wx)));
  endtask

  initial begin
    for (int i = 0; i < HOT_KEYS; i++)
      hot_keys[i] = (i < DEFAULT_BINDINGS) ? BOOT_KEYS[i] : 9'($urandom_range(0, 511));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed corner cases
    send_command(kef_in_t'{CMD_POP,      9'd0,   1'b0, 4'd0});   // pop of empty queue
    send_command(kef_in_t'{CMD_KEY_DOWN, 9'd26,  1'b0, 4'd0});   // first default key
    send_command(kef_in_t'{CMD_KEY_DOWN, 9'd60,  1'b0, 4'd0});   // last default key
    send_command(kef_in_t'{CMD_KEY_DOWN, 9'd26,  1'b1, 4'd0});   // autorepeat ignored
    send_command(kef_in_t'{CMD_KEY_DOWN, 9'h1FF, 1'b0, 4'd0});   // unmapped keys
    send_command(kef_in_t'{CMD_KEY_DOWN, 9'd0,   1'b0, 4'd0});
    send_command(kef_in_t'{CMD_PUSH,     9'd0,   1'b0, 4'd0});   // push of none
    send_command(kef_in_t'{CMD_PUSH,     9'd0,   1'b0, 4'd9});
    send_command(kef_in_t'{CMD_PUSH,     9'd0,   1'b0, 4'd10});  // out-of-range events
    send_command(kef_in_t'{CMD_PUSH,     9'h1FF, 1'b1, 4'd15});
    send_command(kef_in_t'{CMD_PUSH,     9'd0,   1'b0, 4'd1});
    send_command(kef_in_t'{CMD_BIND,     9'd26,  1'b0, 4'd12});  // bind rejected
    send_command(kef_in_t'{CMD_BIND,     9'd26,  1'b0, 4'd0});   // bind to none
    send_command(kef_in_t'{CMD_KEY_DOWN, 9'd26,  1'b0, 4'd0});   // key now maps to none
    send_command(kef_in_t'{CMD_BIND,     9'h1FF, 1'b0, 4'd5});   // new binding
    send_command(kef_in_t'{CMD_KEY_DOWN, 9'h1FF, 1'b0, 4'd0});
    send_command(kef_in_t'{CMD_POP,      9'd0,   1'b0, 4'd0});
    send_command(kef_in_t'{CMD_POP,      9'd0,   1'b0, 4'd0});
    send_command(kef_in_t'{CMD_SPARE6,   9'h1FF, 1'b1, 4'hF});   // unused commands
    send_command(kef_in_t'{CMD_SPARE7,   9'h1FF, 1'b1, 4'hF});
    send_command(kef_in_t'{CMD_CLEAR,    9'd0,   1'b0, 4'd0});
    send_command(kef_in_t'{CMD_POP,      9'd0,   1'b0, 4'd0});
    send_command(kef_in_t'{CMD_RESTORE,  9'd0,   1'b0, 4'd0});
    send_command(kef_in_t'{CMD_KEY_DOWN, 9'd26,  1'b0, 4'd0});

    // Mixed traffic
    run_phase(250, 4, 3, 2, 3, 1, 1, 1);
    wait_for_results();

    // Push-heavy: queue fills and drops its oldest events
    run_phase(100, 5, 5, 1, 2, 0, 0, 0);
    idle_en <= 1'b0;
    run_phase(100, 5, 5, 1, 2, 0, 0, 0);
    idle_en <= 1'b1;

    // Bind-heavy: map fills up, then binds fail
    run_phase(150, 3, 1, 6, 1, 0, 1, 0);
    wait_for_results();

    // Pop-heavy: queue runs dry
    run_phase(100, 2, 1, 1, 6, 1, 1, 1);

    // Closing stretch without gaps
    idle_en <= 1'b0;
    run_phase(150, 4, 3, 2, 3, 1, 1, 1);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kef_pkg.sv
rtl/kef_map.sv
rtl/keymap_event_fifo.sv
dv/keymap_event_fifo_tb.sv
